### hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared widths, constants and decode functions of the rtc sample
// stabilize and decode block.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned S_USER_W = 2;
    localparam int unsigned M_DATA_W = 64;
    localparam int unsigned SAMPLE_W = 56;
    localparam int unsigned YEAR_W   = 14;

    // tuser bit positions on the input side
    localparam int unsigned USER_BINARY = 0;
    localparam int unsigned USER_H24    = 1;

    // full_year position in the output tdata
    localparam int unsigned YEAR_LSB = 48;

    localparam logic [7:0] HOUR_NOON   = 8'd12;
    localparam logic [7:0] HOURS_DAY   = 8'd24;
    localparam logic [7:0] CENTURY_MIN = 8'd19;
    localparam logic [7:0] CENTURY_MAX = 8'd99;

    localparam logic [YEAR_W-1:0] YEAR_BASE   = 14'd2000;
    localparam logic [YEAR_W-1:0] YEAR_PIVOT  = 14'd2020;
    localparam logic [YEAR_W-1:0] YEAR_WRAP   = 14'd100;
    localparam logic [YEAR_W-1:0] CENTURY_MUL = 14'd100;
    localparam logic [YEAR_W-1:0] YEAR_LOWEST = 14'd1900;
    localparam logic [YEAR_W-1:0] YEAR_TOP    = 14'd10155;

    // nibbles above nine are not checked, 0xff gives 165
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return {4'd0, v[3:0]} + 8'(hi * 8'd10);
    endfunction

    // value is at most 139 here, so five subtractions cover it
    function automatic logic [7:0] mod_day(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= HOURS_DAY) begin
                r = r - HOURS_DAY;
            end
        end
        return r;
    endfunction

    // fold the pm flag in bit 7 into a 24-hour value
    function automatic logic [7:0] hour_to_24(input logic [7:0] hr);
        logic [7:0] h;
        logic [7:0] res;
        h = {1'b0, hr[6:0]};
        if (hr[7]) begin
            res = (h == HOUR_NOON) ? HOUR_NOON : mod_day(h + HOUR_NOON);
        end else begin
            res = (h == HOUR_NOON) ? 8'd0 : h;
        end
        return res;
    endfunction

endpackage

### hw/rtl/rtc_sample_stabilize_decode_top.sv
// ----------------------------------------------------------------------------
// rtc_sample_stabilize_decode_top
// Pairs raw rtc samples and emits one decoded 24-hour, four-digit-year time
// for every pair whose seven time bytes agree.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while results are taken. Every two
// accepted samples form a pair: the first is held, the second is compared
// with it on the seven time bytes (century and format flags excluded). A
// match enters a one-entry input register and is decoded from there into
// the output register, which drives the master side, and the block keeps
// accepting one sample every cycle as long as results are taken. A
// mismatch gives no result and the next sample starts a new pair.
// Decoding applies bcd conversion unless binary mode is set, folds the
// 12-hour pm flag into 24-hour form unless 24-hour mode is set (12 pm is
// 12, 12 am is 0) and windows the century: 19..99 is used as is,
// otherwise 2000 + year, moved up a century when below 2020.
module rtc_sample_stabilize_decode_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // raw_second, raw_minute, raw_hour, raw_weekday, raw_day, raw_month,
    // raw_year, raw_century
    input  logic [rsd_pkg::S_DATA_W-1:0]  i_s_tdata,
    // binary_mode, hour_24_mode
    input  logic [rsd_pkg::S_USER_W-1:0]  i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // seconds, minutes, hours, day_of_week, day_of_month, month_number,
    // full_year[13:0], 2 zero bits
    output logic [rsd_pkg::M_DATA_W-1:0]  o_m_tdata
);

    logic                          r_holding;
    logic [rsd_pkg::SAMPLE_W-1:0]  r_held;
    logic                          r_s1_vld;
    logic [rsd_pkg::S_DATA_W-1:0]  r_s1_data;
    logic [rsd_pkg::S_USER_W-1:0]  r_s1_user;
    logic                          r_m_vld;
    logic [rsd_pkg::M_DATA_W-1:0]  r_m_data;
    logic [rsd_pkg::M_DATA_W-1:0]  n_m_data;

    logic s_acc;
    logic m_free;
    logic s1_adv;
    logic pair_match;

    assign m_free     = !r_m_vld || i_m_tready;
    assign s1_adv     = r_s1_vld && m_free;
    assign o_s_tready = !r_s1_vld || m_free;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign pair_match = r_holding && (i_s_tdata[rsd_pkg::SAMPLE_W-1:0] == r_held);

    assign o_m_tvalid = r_m_vld;
    assign o_m_tdata  = r_m_data;

    // decode of the registered matching sample
    always_comb begin
        logic [7:0]                  sec, mnt, hr, wd, dy, mo, yr, cen;
        logic [7:0]                  hr_lo;
        logic [rsd_pkg::YEAR_W-1:0]  year;
        sec = r_s1_data[0*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        mnt = r_s1_data[1*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        hr  = r_s1_data[2*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        wd  = r_s1_data[3*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        dy  = r_s1_data[4*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        mo  = r_s1_data[5*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        yr  = r_s1_data[6*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        cen = r_s1_data[7*rsd_pkg::BYTE_W +: rsd_pkg::BYTE_W];
        hr_lo = rsd_pkg::bcd_to_bin({1'b0, hr[6:0]});
        if (!r_s1_user[rsd_pkg::USER_BINARY]) begin
            sec = rsd_pkg::bcd_to_bin(sec);
            mnt = rsd_pkg::bcd_to_bin(mnt);
            // hour keeps its pm bit, low seven bits decode to at most 85
            hr  = {hr[7], hr_lo[6:0]};
            wd  = rsd_pkg::bcd_to_bin(wd);
            dy  = rsd_pkg::bcd_to_bin(dy);
            mo  = rsd_pkg::bcd_to_bin(mo);
            yr  = rsd_pkg::bcd_to_bin(yr);
            cen = rsd_pkg::bcd_to_bin(cen);
        end
        if (!r_s1_user[rsd_pkg::USER_H24]) begin
            hr = rsd_pkg::hour_to_24(hr);
        end
        if (cen >= rsd_pkg::CENTURY_MIN && cen <= rsd_pkg::CENTURY_MAX) begin
            year = 14'(14'(cen) * rsd_pkg::CENTURY_MUL) + 14'(yr);
        end else begin
            year = rsd_pkg::YEAR_BASE + 14'(yr);
            if (year < rsd_pkg::YEAR_PIVOT) begin
                year = year + rsd_pkg::YEAR_WRAP;
            end
        end
        n_m_data = {2'b00, year, mo, dy, wd, hr, mnt, sec};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_m_vld   <= 1'b0;
        end else begin
            if (s_acc) begin
                r_holding <= !r_holding;
            end
            if (s_acc && pair_match) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && !r_holding) begin
            r_held <= i_s_tdata[rsd_pkg::SAMPLE_W-1:0];
        end
        if (s_acc && pair_match) begin
            r_s1_data <= i_s_tdata;
            r_s1_user <= i_s_tuser;
        end
        if (s1_adv) begin
            r_m_data <= n_m_data;
        end
    end

endmodule

### hw/rtl/rsd_checker.sv
// ----------------------------------------------------------------------------
// rsd_checker
// Port-level checks of the rtc sample stabilize and decode block.
// ----------------------------------------------------------------------------
module rsd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [rsd_pkg::S_DATA_W-1:0]  i_s_tdata,
    input logic [rsd_pkg::S_USER_W-1:0]  i_s_tuser,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [rsd_pkg::M_DATA_W-1:0]  o_m_tdata
);

    logic [rsd_pkg::YEAR_W-1:0] out_year;
    assign out_year = o_m_tdata[rsd_pkg::YEAR_LSB +: rsd_pkg::YEAR_W];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // an empty output side never blocks a new transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // century windowing keeps the year in range and the padding is zero
    a_year_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> out_year >= rsd_pkg::YEAR_LOWEST && out_year <= rsd_pkg::YEAR_TOP
            && o_m_tdata[rsd_pkg::M_DATA_W-1:rsd_pkg::YEAR_LSB+rsd_pkg::YEAR_W] == 2'b00)
        else $error("full year outside window");

endmodule

bind rtc_sample_stabilize_decode_top rsd_checker u_rsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rtc sample pairing and time decode block.
// A short run of corner samples is followed by random stable pairs, broken
// pairs and lone noise samples. Both stream sides stall at random, and every
// decoded time is compared with an in-bench decoder.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_GAP        = 17;
    localparam int RANDOM_SAMPLES = 400;
    localparam int LONG_HOLD      = 300;
    localparam int BURST_PAIRS    = 20;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int CYCLE_LIMIT    = 200000;

    typedef logic [rsd_pkg::S_USER_W-1:0] t_user;

    // one decoded time, seconds in the lowest byte as on o_m_tdata
    typedef struct packed {
        logic [1:0]                 pad;
        logic [rsd_pkg::YEAR_W-1:0] full_year;
        logic [7:0]                 month_number;
        logic [7:0]                 day_of_month;
        logic [7:0]                 day_of_week;
        logic [7:0]                 hours;
        logic [7:0]                 minutes;
        logic [7:0]                 seconds;
    } t_rtc_time;

    class t_rtc_time_scoreboard;
        logic [rsd_pkg::SAMPLE_W-1:0] held_bytes;
        bit                           holding;
        t_rtc_time                    expected_q[$];
        int                           errors;
        int                           samples_seen;
        int                           times_checked;
        int                           pairs_broken;

        function new();
            held_bytes    = '0;
            holding       = 1'b0;
            errors        = 0;
            samples_seen  = 0;
            times_checked = 0;
            pairs_broken  = 0;
        endfunction

        function logic [7:0] bcd_value(logic [7:0] v);
            return 8'(int'(v[3:0]) + int'(v[7:4]) * 10);
        endfunction

        function t_rtc_time decode_time(logic [rsd_pkg::S_DATA_W-1:0] data,
                                        logic [rsd_pkg::S_USER_W-1:0] user);
            logic [7:0] b [8];
            bit         bin;
            bit         h24;
            int         hr;
            int         h;
            int         cen;
            int         yr;
            int         year_v;
            t_rtc_time  t;
            for (int i = 0; i < 8; i++) begin
                b[i] = data[8*i +: 8];
            end
            bin = user[rsd_pkg::USER_BINARY];
            h24 = user[rsd_pkg::USER_H24];
            if (!bin) begin
                for (int i = 0; i < 8; i++) begin
                    if (i != 2) begin
                        b[i] = bcd_value(b[i]);
                    end
                end
                // pm flag stays, only the low seven bits are bcd
                b[2] = {b[2][7], 7'(bcd_value({1'b0, b[2][6:0]}))};
            end
            hr = b[2];
            if (!h24) begin
                h = b[2][6:0];
                if (b[2][7]) begin
                    hr = (h == 12) ? 12 : (h + 12) % 24;
                end else begin
                    hr = (h == 12) ? 0 : h;
                end
            end
            cen = b[7];
            yr  = b[6];
            if (cen >= 19 && cen <= 99) begin
                year_v = cen * 100 + yr;
            end else begin
                year_v = 2000 + yr;
                if (year_v < 2020) begin
                    year_v += 100;
                end
            end
            t.pad          = '0;
            t.seconds      = b[0];
            t.minutes      = b[1];
            t.hours        = 8'(hr);
            t.day_of_week  = b[3];
            t.day_of_month = b[4];
            t.month_number = b[5];
            t.full_year    = year_v[rsd_pkg::YEAR_W-1:0];
            return t;
        endfunction

        function void note_sample(logic [rsd_pkg::S_DATA_W-1:0] data,
                                  logic [rsd_pkg::S_USER_W-1:0] user);
            samples_seen++;
            if (!holding) begin
                held_bytes = data[rsd_pkg::SAMPLE_W-1:0];
                holding    = 1'b1;
            end else begin
                holding = 1'b0;
                if (data[rsd_pkg::SAMPLE_W-1:0] == held_bytes) begin
                    expected_q.push_back(decode_time(data, user));
                end else begin
                    pairs_broken++;
                end
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [rsd_pkg::M_DATA_W-1:0] data);
            t_rtc_time got;
            t_rtc_time want;
            got = data;
            times_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: time out with none expected, expected nothing, actual %h",
                         $time, data);
                return;
            end
            want = expected_q.pop_front();
            compare_field("seconds", want.seconds, got.seconds);
            compare_field("minutes", want.minutes, got.minutes);
            compare_field("hours", want.hours, got.hours);
            compare_field("day_of_week", want.day_of_week, got.day_of_week);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("month_number", want.month_number, got.month_number);
            compare_field("full_year", want.full_year, got.full_year);
            compare_field("pad bits", want.pad, got.pad);
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    // raw_second, raw_minute, raw_hour, raw_weekday, raw_day, raw_month,
    // raw_year, raw_century
    logic [rsd_pkg::S_DATA_W-1:0] i_s_tdata;
    // binary_mode, hour_24_mode
    logic [rsd_pkg::S_USER_W-1:0] i_s_tuser;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    // seconds, minutes, hours, day_of_week, day_of_month, month_number,
    // full_year[13:0], 2 zero bits
    logic [rsd_pkg::M_DATA_W-1:0] o_m_tdata;

    t_rtc_time_scoreboard sb = new();

    bit no_idle       = 1'b0;
    bit burst         = 1'b0;
    bit long_hold_req = 1'b0;
    bit pair_open     = 1'b0;
    int samples_sent  = 0;
    int long_holds    = 0;
    int cycle_count   = 0;

    rtc_sample_stabilize_decode_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit reached with %0d times still expected",
                     $time, sb.expected_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_sample(i_s_tdata, i_s_tuser);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
            end
        end
    end

    function automatic logic [7:0] to_bcd(int n);
        return {4'(n / 10), 4'(n % 10)};
    endfunction

    function automatic logic [rsd_pkg::S_USER_W-1:0] fmt(bit bin, bit h24);
        logic [rsd_pkg::S_USER_W-1:0] u;
        u                       = '0;
        u[rsd_pkg::USER_BINARY] = bin;
        u[rsd_pkg::USER_H24]    = h24;
        return u;
    endfunction

    function automatic logic [rsd_pkg::S_DATA_W-1:0] pack_bytes(
        logic [7:0] sec, logic [7:0] min, logic [7:0] hr, logic [7:0] wd,
        logic [7:0] dy, logic [7:0] mo, logic [7:0] yr, logic [7:0] cen);
        return {cen, yr, mo, dy, wd, hr, min, sec};
    endfunction

    function automatic logic [rsd_pkg::S_DATA_W-1:0] random_sample();
        return {$urandom, $urandom};
    endfunction

    // a sample as a working clock would give it, coded as the format says
    function automatic logic [rsd_pkg::S_DATA_W-1:0] plausible_sample(bit bin, bit h24);
        int         v [8];
        logic [7:0] b [8];
        bit         pm;
        v[0] = $urandom_range(0, 59);
        v[1] = $urandom_range(0, 59);
        v[3] = $urandom_range(1, 7);
        v[4] = $urandom_range(1, 31);
        v[5] = $urandom_range(1, 12);
        v[6] = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: v[7] = 19;
            1: v[7] = 20;
            2: v[7] = 21;
            default: v[7] = $urandom_range(0, 99);
        endcase
        if (h24) begin
            v[2] = $urandom_range(0, 23);
            pm   = 1'b0;
        end else begin
            v[2] = $urandom_range(1, 12);
            pm   = $urandom_range(0, 1);
        end
        for (int i = 0; i < 8; i++) begin
            b[i] = bin ? 8'(v[i]) : to_bcd(v[i]);
        end
        b[2][7] = pm;
        return {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
    endfunction

    task automatic send_sample(input logic [rsd_pkg::S_DATA_W-1:0] data,
                               input logic [rsd_pkg::S_USER_W-1:0] user);
        int gap;
        gap = (no_idle || burst) ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= user;
        do @(posedge i_clk); while (!o_s_tready);
        samples_sent++;
        pair_open = !pair_open;
    endtask

    task automatic send_twice(input logic [rsd_pkg::S_DATA_W-1:0] data,
                              input logic [rsd_pkg::S_USER_W-1:0] user);
        send_sample(data, user);
        send_sample(data, user);
    endtask

    task automatic send_pair(input bit broken);
        logic [rsd_pkg::S_DATA_W-1:0] first;
        logic [rsd_pkg::S_DATA_W-1:0] second;
        logic [rsd_pkg::S_USER_W-1:0] user;
        bit                           bin;
        bit                           h24;
        int                           idx;
        bin  = $urandom_range(0, 1);
        h24  = $urandom_range(0, 1);
        user = fmt(bin, h24);
        first = $urandom_range(0, 1) ? plausible_sample(bin, h24) : random_sample();
        second = first;
        // century is not compared, only the second one counts
        if ($urandom_range(0, 3) == 0) begin
            second[rsd_pkg::S_DATA_W-1 -: 8] = 8'($urandom);
        end
        if (broken) begin
            idx = $urandom_range(0, rsd_pkg::SAMPLE_W - 1);
            second[idx] = ~second[idx];
        end
        // a filler sample closes a half-open pair first
        if (pair_open) begin
            send_sample(random_sample(), t_user'($urandom));
        end
        send_sample(first, user);
        send_sample(second, ($urandom_range(0, 7) == 0) ? t_user'($urandom) : user);
    endtask

    task automatic wait_for_results();
        // stop offering so the last sample is not taken again
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : result_sink
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
                long_holds++;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    initial begin : stimulus
        int base;
        int r;
        int drain_wait;
        bit pressure_done;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        pressure_done = 1'b0;
        drain_wait    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner samples
        send_twice('0, fmt(0, 0));
        send_twice('1, fmt(0, 0));
        send_twice('1, fmt(1, 1));
        // 12 pm stays 12
        send_twice(pack_bytes(8'h59, 8'h59, 8'h92, 8'h07, 8'h31, 8'h12, 8'h24, 8'h20),
                   fmt(0, 0));
        // 12 am becomes 0, lowest windowed century
        send_twice(pack_bytes(8'h00, 8'h30, 8'h12, 8'h01, 8'h01, 8'h01, 8'h99, 8'h19),
                   fmt(0, 0));
        // 11 pm, highest windowed century
        send_twice(pack_bytes(8'h45, 8'h15, 8'h91, 8'h05, 8'h28, 8'h02, 8'h99, 8'h99),
                   fmt(0, 0));
        // 24-hour binary keeps bit 7, year below the pivot moves up
        send_twice(pack_bytes(8'd59, 8'd0, 8'h97, 8'd6, 8'd15, 8'd7, 8'd19, 8'd18),
                   fmt(1, 1));
        // binary 12 pm, century above the window
        send_twice(pack_bytes(8'd1, 8'd2, 8'h8c, 8'd3, 8'd4, 8'd5, 8'd6, 8'd100),
                   fmt(1, 0));
        send_twice(pack_bytes(8'h10, 8'h20, 8'h23, 8'h04, 8'h10, 8'h10, 8'h00, 8'h21),
                   fmt(0, 1));
        // minute changed between the two reads
        send_sample(pack_bytes(8'h10, 8'h20, 8'h08, 8'h04, 8'h10, 8'h10, 8'h00, 8'h20),
                    fmt(0, 0));
        send_sample(pack_bytes(8'h10, 8'h21, 8'h08, 8'h04, 8'h10, 8'h10, 8'h00, 8'h20),
                    fmt(0, 0));
        // century and format differ, pair still matches
        send_sample(pack_bytes(8'h05, 8'h06, 8'h07, 8'h01, 8'h02, 8'h03, 8'h04, 8'h19),
                    fmt(0, 0));
        send_sample(pack_bytes(8'h05, 8'h06, 8'h07, 8'h01, 8'h02, 8'h03, 8'h04, 8'h20),
                    fmt(1, 1));

        base = samples_sent;
        while (samples_sent < base + RANDOM_SAMPLES) begin
            if ($urandom_range(0, 24) == 0) begin
                no_idle = !no_idle;
            end
            if (!pressure_done && samples_sent >= base + RANDOM_SAMPLES / 3) begin
                // sink holds off while samples keep coming back to back
                pressure_done = 1'b1;
                burst         = 1'b1;
                long_hold_req = 1'b1;
                repeat (BURST_PAIRS) send_pair(1'b0);
                burst = 1'b0;
                wait_for_results();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                send_pair(1'b0);
            end else if (r < 85) begin
                send_pair(1'b1);
            end else begin
                send_sample(random_sample(), t_user'($urandom));
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (sb.expected_q.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            sb.errors += sb.expected_q.size();
            $display("%0t: %0d decoded times never came out", $time, sb.expected_q.size());
        end

        $display("tb_top: %0d samples in, %0d times checked, %0d broken pairs",
                 sb.samples_seen, sb.times_checked, sb.pairs_broken);
        $display("tb_top: bcd and binary, 12 and 24 hour, century window, %0d long sink hold",
                 long_holds);
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
